// ===== hdl/stt_pkg.sv =====
// Shared types, codes and byte classification for the source text tokenizer.
`default_nettype none

package stt_pkg;

    localparam int STT_POSITION_BITS = 32;
    localparam int KEYWORD_BYTES     = 8;
    localparam int KEYWORD_COUNT     = 13;
    localparam int WINDOW_BITS       = 8 * KEYWORD_BYTES;
    localparam int KIND_BITS         = 6;
    localparam int FIELD_BITS        = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_BITS-1:0] LEN_MAX = '1;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_NUMBER = 3'd1;
    localparam logic [2:0] MODE_IDENT  = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_EQ     = 3'd4;
    localparam logic [2:0] MODE_LT     = 3'd5;
    localparam logic [2:0] MODE_SKIP   = 3'd6;

    localparam logic [KIND_BITS-1:0] KIND_EQ       = 6'd0;
    localparam logic [KIND_BITS-1:0] KIND_EQEQ     = 6'd1;
    localparam logic [KIND_BITS-1:0] KIND_PLUS     = 6'd2;
    localparam logic [KIND_BITS-1:0] KIND_DOT      = 6'd3;
    localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd4;
    localparam logic [KIND_BITS-1:0] KIND_LT       = 6'd5;
    localparam logic [KIND_BITS-1:0] KIND_LE       = 6'd6;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd7;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd8;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 6'd9;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 6'd10;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd11;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd12;
    localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd13;
    localparam logic [KIND_BITS-1:0] KIND_COLON    = 6'd14;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 6'd15;
    localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd16;
    localparam logic [KIND_BITS-1:0] KIND_STRING   = 6'd17;
    localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 6'd18;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 6'd31;
    localparam logic [KIND_BITS-1:0] KIND_END      = 6'd32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    localparam logic [WINDOW_BITS-1:0] KEYWORD_TEXT [KEYWORD_COUNT] = '{
        WINDOW_BITS'("let"),
        WINDOW_BITS'("function"),
        WINDOW_BITS'("and"),
        WINDOW_BITS'("or"),
        WINDOW_BITS'("not"),
        WINDOW_BITS'("do"),
        WINDOW_BITS'("type"),
        WINDOW_BITS'("for"),
        WINDOW_BITS'("in"),
        WINDOW_BITS'("return"),
        WINDOW_BITS'("if"),
        WINDOW_BITS'("while"),
        WINDOW_BITS'("else")
    };

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  done;
    } token_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
    endfunction

    // Single-character symbol lookup; returns valid flag and kind.
    function automatic logic [KIND_BITS:0] symbol_kind(input logic [7:0] b);
        logic [KIND_BITS:0] r;
        case (b)
            8'h2B:   r = {1'b1, KIND_PLUS};
            8'h2E:   r = {1'b1, KIND_DOT};
            8'h2C:   r = {1'b1, KIND_COMMA};
            8'h28:   r = {1'b1, KIND_LPAREN};
            8'h7B:   r = {1'b1, KIND_LBRACE};
            8'h5B:   r = {1'b1, KIND_LBRACKET};
            8'h5D:   r = {1'b1, KIND_RBRACKET};
            8'h7D:   r = {1'b1, KIND_RBRACE};
            8'h29:   r = {1'b1, KIND_RPAREN};
            8'h3B:   r = {1'b1, KIND_SEMI};
            8'h3A:   r = {1'b1, KIND_COLON};
            default: r = {1'b0, KIND_EQ};
        endcase
        return r;
    endfunction

    // Match the identifier window against the keyword list.
    function automatic logic [KIND_BITS-1:0] ident_kind(
        input logic [WINDOW_BITS-1:0] win,
        input logic [FIELD_BITS-1:0]  len
    );
        logic [KIND_BITS-1:0] kind;
        logic                 hit;
        kind = KIND_IDENT;
        hit  = 1'b0;
        if (len <= FIELD_BITS'(KEYWORD_BYTES)) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (!hit && win == KEYWORD_TEXT[k]) begin
                    kind = KIND_KEYWORD0 + KIND_BITS'(k);
                    hit  = 1'b1;
                end
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/source_text_tokenizer.sv =====
// Streaming tokenizer: one source byte per request in, tokens out through a short queue.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, text_byte, final_byte        | sink
//  out     | out_valid, out_ready, token_kind, token_start,   | source
//          | token_length, stream_done                        |
//
// One byte is scanned per cycle while the queue has room: input register, one pass of scan logic, token queue.
// A byte yields zero, one or two tokens; the queue drains one token per cycle while out_ready
// is high, so a run of two-token bytes is limited by the output port.
// An accepted byte passes the input register and then the token queue before its first token reaches the port.
// The scanner stalls while the queue has fewer than two free entries.
// Reset is asynchronous; no clearing pass is needed.
`default_nettype none

module source_text_tokenizer #(
    parameter int POSITION_BITS = stt_pkg::STT_POSITION_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         text_byte,
    input  wire logic                               final_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [stt_pkg::KIND_BITS-1:0]           token_kind,
    output logic [stt_pkg::FIELD_BITS-1:0]          token_start,
    output logic [stt_pkg::FIELD_BITS-1:0]          token_length,
    output logic                                    stream_done
);
    import stt_pkg::*;

    logic                       s1_valid_reg, s1_valid_next;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_final_reg;

    logic [2:0]                 mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   pstart_reg, pstart_next;
    logic [FIELD_BITS-1:0]      plen_reg, plen_next;
    logic [WINDOW_BITS-1:0]     win_reg, win_next;

    token_t                     q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0]  count_reg, count_next;

    token_t                     res [2];
    logic [1:0]                 n_emit;
    logic                       advance;
    logic                       pop;
    logic                       handled;
    logic [KIND_BITS:0]         sym;
    logic [FIELD_BITS-1:0]      grown;
    logic [POSITION_BITS-1:0]   pos_inc;
    logic [7:0]                 b;

    function automatic token_t tok(
        input logic [KIND_BITS-1:0]  k,
        input logic [FIELD_BITS-1:0] s,
        input logic [FIELD_BITS-1:0] l
    );
        token_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.done   = 1'b0;
        return t;
    endfunction

    assign advance  = s1_valid_reg && (count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
    assign in_ready = !s1_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    assign b       = s1_byte_reg;
    assign sym     = symbol_kind(s1_byte_reg);
    assign grown   = (plen_reg == LEN_MAX) ? plen_reg : plen_reg + FIELD_BITS'(1);
    assign pos_inc = pos_reg + POSITION_BITS'(1);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        win_next    = win_reg;
        res[0]      = '0;
        res[1]      = '0;
        n_emit      = 2'd0;
        handled     = 1'b0;

        if (advance)
        begin
            case (mode_reg)
                MODE_SKIP:
                begin
                    handled = 1'b1;
                end
                MODE_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        plen_next = grown;
                        handled   = 1'b1;
                    end
                    else
                    begin
                        res[n_emit[0]] = tok(KIND_NUMBER, FIELD_BITS'(pstart_reg), plen_reg);
                        n_emit         = n_emit + 2'd1;
                        mode_next      = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b))
                    begin
                        plen_next = grown;
                        win_next  = {win_reg[WINDOW_BITS-9:0], b};
                        handled   = 1'b1;
                    end
                    else
                    begin
                        res[n_emit[0]] = tok(ident_kind(win_reg, plen_reg),
                                             FIELD_BITS'(pstart_reg), plen_reg);
                        n_emit         = n_emit + 2'd1;
                        mode_next      = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    handled = 1'b1;
                    if (b == CHAR_QUOTE)
                    begin
                        res[n_emit[0]] = tok(KIND_STRING, FIELD_BITS'(pstart_reg), plen_reg);
                        n_emit         = n_emit + 2'd1;
                        mode_next      = MODE_IDLE;
                    end
                    else if (b == CHAR_NUL)
                    begin
                        res[n_emit[0]] = tok(KIND_ERROR, FIELD_BITS'(pos_reg), FIELD_BITS'(1));
                        n_emit         = n_emit + 2'd1;
                        mode_next      = MODE_SKIP;
                    end
                    else
                    begin
                        plen_next = grown;
                    end
                end
                MODE_EQ, MODE_LT:
                begin
                    if (b == CHAR_EQ)
                    begin
                        res[n_emit[0]] = tok((mode_reg == MODE_EQ) ? KIND_EQEQ : KIND_LE,
                                             FIELD_BITS'(pstart_reg), FIELD_BITS'(2));
                        handled        = 1'b1;
                    end
                    else
                    begin
                        res[n_emit[0]] = tok((mode_reg == MODE_EQ) ? KIND_EQ : KIND_LT,
                                             FIELD_BITS'(pstart_reg), FIELD_BITS'(1));
                    end
                    n_emit    = n_emit + 2'd1;
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase

            if (!handled)
            begin
                if (b == CHAR_EQ || b == CHAR_LT)
                begin
                    mode_next   = (b == CHAR_EQ) ? MODE_EQ : MODE_LT;
                    pstart_next = pos_reg;
                    plen_next   = FIELD_BITS'(1);
                end
                else if (sym[KIND_BITS])
                begin
                    res[n_emit[0]] = tok(sym[KIND_BITS-1:0], FIELD_BITS'(pos_reg),
                                         FIELD_BITS'(1));
                    n_emit         = n_emit + 2'd1;
                end
                else if (is_space(b))
                begin
                    mode_next = mode_next;
                end
                else if (is_digit(b))
                begin
                    mode_next   = MODE_NUMBER;
                    pstart_next = pos_reg;
                    plen_next   = FIELD_BITS'(1);
                end
                else if (is_alpha(b))
                begin
                    mode_next   = MODE_IDENT;
                    pstart_next = pos_reg;
                    plen_next   = FIELD_BITS'(1);
                    win_next    = WINDOW_BITS'(b);
                end
                else if (b == CHAR_QUOTE)
                begin
                    mode_next   = MODE_STRING;
                    pstart_next = pos_inc;
                    plen_next   = '0;
                end
                else
                begin
                    res[n_emit[0]] = tok(KIND_ERROR, FIELD_BITS'(pos_reg), FIELD_BITS'(1));
                    n_emit         = n_emit + 2'd1;
                    mode_next      = MODE_SKIP;
                end
            end

            if (s1_final_reg)
            begin
                case (mode_next)
                    MODE_NUMBER:
                    begin
                        res[n_emit[0]] = tok(KIND_NUMBER, FIELD_BITS'(pstart_next), plen_next);
                        n_emit         = n_emit + 2'd1;
                    end
                    MODE_IDENT:
                    begin
                        res[n_emit[0]] = tok(ident_kind(win_next, plen_next),
                                             FIELD_BITS'(pstart_next), plen_next);
                        n_emit         = n_emit + 2'd1;
                    end
                    MODE_STRING:
                    begin
                        res[n_emit[0]] = tok(KIND_ERROR, FIELD_BITS'(pstart_next), plen_next);
                        n_emit         = n_emit + 2'd1;
                    end
                    MODE_EQ:
                    begin
                        res[n_emit[0]] = tok(KIND_EQ, FIELD_BITS'(pstart_next), FIELD_BITS'(1));
                        n_emit         = n_emit + 2'd1;
                    end
                    MODE_LT:
                    begin
                        res[n_emit[0]] = tok(KIND_LT, FIELD_BITS'(pstart_next), FIELD_BITS'(1));
                        n_emit         = n_emit + 2'd1;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase

                if (n_emit == 2'd0)
                begin
                    res[0] = tok(KIND_END, FIELD_BITS'(pos_inc), '0);
                    n_emit = 2'd1;
                end

                if (n_emit == 2'd2)
                begin
                    res[1].done = 1'b1;
                end
                else
                begin
                    res[0].done = 1'b1;
                end

                mode_next   = MODE_IDLE;
                pos_next    = '0;
                pstart_next = '0;
                plen_next   = '0;
                win_next    = '0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(n_emit);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + QUEUE_CNT_BITS'(n_emit) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            pstart_reg   <= '0;
            plen_reg     <= '0;
            win_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            pstart_reg   <= pstart_next;
            plen_reg     <= plen_next;
            win_reg      <= win_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= text_byte;
            s1_final_reg <= final_byte;
        end
        if (n_emit != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res[0];
        end
        if (n_emit == 2'd2)
        begin
            q_reg[wr_ptr_reg + QUEUE_PTR_BITS'(1)] <= res[1];
        end
    end

    assign out_valid    = (count_reg != '0);
    assign token_kind   = q_reg[rd_ptr_reg].kind;
    assign token_start  = q_reg[rd_ptr_reg].start;
    assign token_length = q_reg[rd_ptr_reg].length;
    assign stream_done  = q_reg[rd_ptr_reg].done;

endmodule

`default_nettype wire

// ===== hdl/stt_checker.sv =====
// Port-level assertions for the source text tokenizer, bound to its top level.
`default_nettype none

module stt_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [stt_pkg::KIND_BITS-1:0]      token_kind,
    input  wire logic [stt_pkg::FIELD_BITS-1:0]     token_start,
    input  wire logic [stt_pkg::FIELD_BITS-1:0]     token_length,
    input  wire logic                               stream_done
);
    import stt_pkg::*;

    // Hold a stalled token until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(token_start) && $stable(token_length) && $stable(stream_done))
    else $error("stalled token changed");

    // End token only closes a stream and carries no text.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> stream_done && token_length == '0)
    else $error("malformed end token");

    // Two-character operators span two bytes, other symbols one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_EQEQ || token_kind == KIND_LE)
            |-> token_length == FIELD_BITS'(2))
    else $error("pair operator length");

    // Kind stays inside the defined code range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= KIND_END)
    else $error("token kind out of range");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .stream_done  (stream_done)
);

`default_nettype wire
